// File: rtl/fmdb_pkg.sv
`default_nettype none
package fmdb_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_NORM,
		ST_SQR,
		ST_SQW,
		ST_SC1,
		ST_SC2,
		ST_SC3,
		ST_FRAME,
		ST_AVG,
		ST_DIVW,
		ST_SUM
	} fmdb_state_t;

	typedef enum logic {
		REC_FRAME   = 1'b0,
		REC_SUMMARY = 1'b1
	} fmdb_rec_t;

	localparam int unsigned ENERGY_W = 43;
	localparam int unsigned CNT_W    = 13;
	localparam int unsigned LOG_W    = 22;

	localparam logic [12:0] DEFAULT_LEN = 13'd1600;
	// 10*log10(2) * 256 * 2^16, split in two 13-bit halves
	localparam logic [12:0] LS_LO = 13'd773;
	localparam logic [12:0] LS_HI = 13'd6165;

	localparam logic signed [15:0] FLOOR_DB = -16'sd25600;
	localparam logic [15:0] AVG_LIMIT = 16'd25600;
	localparam logic [5:0] TOP_EXP = 6'd42;

endpackage
`default_nettype wire

// File: rtl/fmdb_mul.sv
`default_nettype none
module fmdb_mul
	import fmdb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p
);

	// registered 32x32 product
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule
`default_nettype wire

// File: rtl/fmdb_div.sv
`default_nettype none
module fmdb_div
	import fmdb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] num,
	input  wire logic [15:0] den,
	output logic             done,
	output logic      [32:0] quot
);

	logic [32:0] num_q;
	logic [15:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [16:0] rem2;
	logic        ge;

	// one restoring step per cycle
	assign rem2 = {rem_q, num_q[32]};
	assign ge   = rem2 >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd32) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[31:0], ge};
			rem_q <= ge ? 16'(rem2 - {1'b0, den}) : rem2[15:0];
		end
	end

	assign quot = num_q;

endmodule
`default_nettype wire

// File: rtl/frame_rms_db_level_meter.sv
// Frame RMS level meter, levels in 1/256 dB.
// Input channel: sample and end_of_stream, transferred on in_valid & in_ready.
// Config: cfg_we writes frame_length (cfg_wdata) at once; write only while idle.
// Each sample is squared (ST_SQ) and summed (ST_ACC).
// On a frame end with nonzero energy a log2 unit normalizes (one bit shift a
// cycle) and runs 16 squaring rounds (ST_SQR, ST_SQW) on the shared 32x32
// multiplier, for both the energy and the frame length, then scales in
// states ST_SC1 to ST_SC3 before the frame record is offered.
// On end_of_stream the frame record is followed by a summary record; the
// average comes from a bit-serial divider.
// Output channel: one registered record, transferred on out_valid & out_ready.
// A stalled receiver holds the record; the sequencer waits for the register to
// free before loading the next record. in_ready is high only while idle.
// Reset clears all measurement state and sets frame_length to 1600.
`default_nettype none
module frame_rms_db_level_meter
	import fmdb_pkg::*;
#(
	parameter int unsigned MAX_FRAME_LEN = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic        [12:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] sample,
	input  wire logic               end_of_stream,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    record_kind,
	output logic             [15:0] frame_number,
	output logic signed      [15:0] level_db,
	output logic             [14:0] peak_db,
	output logic             [15:0] peak_frame,
	output logic                    silent,
	output logic                    last
);

	localparam int unsigned LEN_CLAMP = (MAX_FRAME_LEN > 8191) ? 8191 : MAX_FRAME_LEN;

	fmdb_state_t state_q, state_d;

	logic [12:0]          flen_q;
	logic [12:0]          eff_len;
	logic signed [15:0]   smp_q;
	logic                 eos_q;
	logic [ENERGY_W-1:0]  energy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [15:0]          fc_q;
	logic signed [15:0]   peak_q;
	logic [15:0]          pidx_q;
	logic signed [31:0]   total_q;

	logic [ENERGY_W-1:0]  xr_q;
	logic [5:0]           exp_q;
	logic [30:0]          m_q;
	logic [15:0]          frac_q;
	logic [3:0]           rnd_q;
	logic                 phase_q;
	logic [LOG_W-1:0]     la_q;
	logic [LOG_W-1:0]     lb_q;
	logic [21:0]          mag_q;
	logic                 neg_q;
	logic [48:0]          acc_q;
	logic signed [15:0]   lvl_q;
	logic                 sil_q;
	logic signed [15:0]   avg_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic        div_start, div_done;
	logic [32:0] div_num, div_quot;

	logic                out_free;
	logic [15:0]         smag;
	logic [ENERGY_W-1:0] energy_n;
	logic [CNT_W-1:0]    cnt_n;
	logic signed [22:0]  dlog;
	logic [21:0]         dmag;
	logic [48:0]         scaled;
	logic [15:0]         qlvl;
	logic [15:0]         fc_n;
	logic signed [33:0]  tot_sum;
	logic signed [31:0]  tot_n;
	logic [31:0]         tmag;
	logic [15:0]         qavg;
	logic [15:0]         frac_n;

	fmdb_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	fmdb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (fc_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// effective frame length
	always_comb begin
		eff_len = flen_q;
		if (flen_q == 13'd0) eff_len = 13'd1;
		else if (flen_q > 13'(LEN_CLAMP)) eff_len = 13'(LEN_CLAMP);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid || out_ready;

	// datapath helpers
	assign smag     = smp_q[15] ? 16'(-smp_q) : smp_q;
	assign energy_n = energy_q + ENERGY_W'(mul_p[30:0]);
	assign cnt_n    = cnt_q + 13'd1;
	assign dlog     = $signed({1'b0, la_q}) - $signed({1'b0, lb_q});
	assign dmag     = dlog[22] ? 22'(-dlog) : dlog[21:0];
	assign scaled   = acc_q + {mul_p[35:0], 13'd0} + 49'(64'h8000_0000);
	assign qlvl     = scaled[47:32];
	assign frac_n   = {frac_q[14:0], mul_p[61]};
	assign fc_n     = (fc_q == 16'hFFFF) ? fc_q : fc_q + 16'd1;
	assign tot_sum  = 34'(total_q) + 34'(lvl_q);
	assign tmag     = total_q[31] ? 32'(-total_q) : total_q;
	assign div_num  = {1'b0, tmag} + {18'd0, fc_q[15:1]};
	assign qavg     = (div_quot > 33'(AVG_LIMIT)) ? AVG_LIMIT : div_quot[15:0];

	always_comb begin
		if (tot_sum > 34'sd2147483647) tot_n = 32'sh7FFF_FFFF;
		else if (tot_sum < -34'sd2147483648) tot_n = 32'sh8000_0000;
		else tot_n = tot_sum[31:0];
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQ: begin
				mul_a = {16'd0, smag};
				mul_b = {16'd0, smag};
			end
			ST_SQR: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			ST_SC1: begin
				mul_a = {10'd0, dmag};
				mul_b = {19'd0, LS_LO};
			end
			ST_SC2: begin
				mul_a = {10'd0, mag_q};
				mul_b = {19'd0, LS_HI};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SQ;
			ST_SQ:    state_d = ST_ACC;
			ST_ACC: begin
				if (cnt_n >= eff_len || eos_q)
					state_d = (energy_n == '0) ? ST_FRAME : ST_NORM;
				else
					state_d = ST_IDLE;
			end
			ST_NORM:  if (xr_q[ENERGY_W-1]) state_d = ST_SQR;
			ST_SQR:   state_d = ST_SQW;
			ST_SQW: begin
				if (rnd_q != 4'd15) state_d = ST_SQR;
				else state_d = phase_q ? ST_SC1 : ST_NORM;
			end
			ST_SC1:   state_d = ST_SC2;
			ST_SC2:   state_d = ST_SC3;
			ST_SC3:   state_d = ST_FRAME;
			ST_FRAME: if (out_free) state_d = eos_q ? ST_AVG : ST_IDLE;
			ST_AVG: begin
				if (fc_q == 16'd0) state_d = ST_SUM;
				else begin
					div_start = 1'b1;
					state_d   = ST_DIVW;
				end
			end
			ST_DIVW:  if (div_done) state_d = ST_SUM;
			ST_SUM:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state register and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			flen_q    <= DEFAULT_LEN;
			energy_q  <= '0;
			cnt_q     <= '0;
			fc_q      <= '0;
			peak_q    <= '0;
			pidx_q    <= '0;
			total_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) flen_q <= cfg_wdata;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_ACC: begin
					if (cnt_n >= eff_len || eos_q) begin
						energy_q <= '0;
						cnt_q    <= '0;
					end else begin
						energy_q <= energy_n;
						cnt_q    <= cnt_n;
					end
				end
				ST_FRAME: begin
					if (out_free) begin
						fc_q      <= fc_n;
						total_q   <= tot_n;
						if (lvl_q > peak_q) begin
							peak_q <= lvl_q;
							pidx_q <= fc_n;
						end
						out_valid <= 1'b1;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						out_valid <= 1'b1;
						energy_q  <= '0;
						cnt_q     <= '0;
						fc_q      <= '0;
						peak_q    <= '0;
						pidx_q    <= '0;
						total_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					smp_q <= sample;
					eos_q <= end_of_stream;
				end
			end
			ST_ACC: begin
				xr_q    <= energy_n;
				exp_q   <= TOP_EXP;
				phase_q <= 1'b0;
				lvl_q   <= FLOOR_DB;
				sil_q   <= (energy_n == '0);
			end
			ST_NORM: begin
				if (xr_q[ENERGY_W-1]) begin
					m_q    <= xr_q[ENERGY_W-1 -: 31];
					frac_q <= '0;
					rnd_q  <= '0;
				end else begin
					xr_q  <= {xr_q[ENERGY_W-2:0], 1'b0};
					exp_q <= exp_q - 6'd1;
				end
			end
			ST_SQW: begin
				frac_q <= frac_n;
				rnd_q  <= rnd_q + 4'd1;
				m_q    <= mul_p[61] ? mul_p[61:31] : mul_p[60:30];
				if (rnd_q == 4'd15) begin
					if (phase_q) lb_q <= {exp_q, frac_n};
					else begin
						la_q    <= {exp_q, frac_n};
						xr_q    <= ENERGY_W'(eff_len);
						exp_q   <= TOP_EXP;
						phase_q <= 1'b1;
					end
				end
			end
			ST_SC1: begin
				mag_q <= dmag;
				neg_q <= dlog[22];
			end
			ST_SC2: acc_q <= 49'(mul_p);
			ST_SC3: lvl_q <= neg_q ? 16'(-qlvl) : qlvl;
			ST_AVG: avg_q <= '0;
			ST_DIVW: begin
				if (div_done) avg_q <= total_q[31] ? 16'(-qavg) : qavg;
			end
			default: begin
			end
		endcase
	end

	// output record register
	always_ff @(posedge clk) begin
		if (state_q == ST_FRAME && out_free) begin
			record_kind  <= REC_FRAME;
			frame_number <= fc_n;
			level_db     <= lvl_q;
			peak_db      <= (lvl_q > peak_q) ? lvl_q[14:0] : peak_q[14:0];
			peak_frame   <= (lvl_q > peak_q) ? fc_n : pidx_q;
			silent       <= sil_q;
			last         <= !eos_q;
		end else if (state_q == ST_SUM && out_free) begin
			record_kind  <= REC_SUMMARY;
			frame_number <= fc_q;
			level_db     <= avg_q;
			peak_db      <= peak_q[14:0];
			peak_frame   <= pidx_q;
			silent       <= 1'b0;
			last         <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/fmdb_checker.sv
`default_nettype none
module fmdb_checker
	import fmdb_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               record_kind,
	input wire logic signed [15:0] level_db,
	input wire logic               silent,
	input wire logic               last
);

	// a stalled record holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level_db) && $stable(last))
		else $error("record changed while stalled");

	// one sample at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// summary closes the stream
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == REC_SUMMARY |-> last && !silent)
		else $error("summary record malformed");

	// silent frames sit at the floor
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == REC_FRAME && silent |-> level_db == FLOOR_DB)
		else $error("silent frame not floored");

	// a frame record with last low is followed by the summary, not by another frame record
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && record_kind == REC_FRAME && !last
			|=> !out_valid || record_kind == REC_SUMMARY)
		else $error("frame record sequence broken");

endmodule

bind frame_rms_db_level_meter fmdb_checker u_fmdb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.record_kind (record_kind),
	.level_db    (level_db),
	.silent      (silent),
	.last        (last)
);
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
	import fmdb_pkg::*;

	localparam int MAXLEN = 4096;
	localparam longint LSCALE = 64'd50504453;

	typedef struct {
		logic        kind;
		logic [15:0] num;
		logic [15:0] lvl;
		logic [14:0] pk;
		logic [15:0] pkf;
		logic        sil;
		logic        lst;
	} meter_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [12:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] sample = '0;
	logic end_of_stream = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic record_kind;
	logic [15:0] frame_number;
	logic signed [15:0] level_db;
	logic [14:0] peak_db;
	logic [15:0] peak_frame;
	logic silent;
	logic last;

	frame_rms_db_level_meter DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.end_of_stream(end_of_stream), .out_valid(out_valid),
		.out_ready(out_ready), .record_kind(record_kind),
		.frame_number(frame_number), .level_db(level_db), .peak_db(peak_db),
		.peak_frame(peak_frame), .silent(silent), .last(last)
	);

	always #10 clk = ~clk;

	// meter model state
	logic [12:0] len_reg;
	longint unsigned energy_acc;
	int unsigned samp_cnt, frames;
	int peak_lvl;
	int unsigned peak_at;
	longint lvl_sum;

	meter_rec_t pending_recs[$];
	int mismatches = 0;
	int recs_seen = 0;
	int items_sent = 0;
	int frames_seen = 0;
	int summaries_seen = 0;
	bit idle_on = 1'b1;
	bit timed_out = 1'b0;

	function automatic longint log2_fix(longint unsigned x);
		int e;
		longint unsigned m;
		int unsigned fr;
		e = 0;
		fr = 0;
		while (e < 63 && (x >> (e + 1)) != 0) e++;
		if (e >= 30) m = x >> (e - 30);
		else m = x << (30 - e);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			fr = fr << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				fr = fr | 1;
			end
		end
		return longint'(e) * 65536 + longint'(fr);
	endfunction

	function automatic int frame_level(longint unsigned en, longint unsigned ln);
		longint d;
		longint unsigned mag, q;
		d = log2_fix(en) - log2_fix(ln);
		mag = (d < 0) ? longint'(-d) : d;
		q = (mag * LSCALE + (64'd1 << 31)) >> 32;
		return (d < 0) ? -int'(q) : int'(q);
	endfunction

	function automatic meter_rec_t make_rec(logic k, int unsigned n, int l, logic s,
			logic ls);
		meter_rec_t r;
		r.kind = k;
		r.num = n[15:0];
		r.lvl = l[15:0];
		r.pk = peak_lvl[14:0];
		r.pkf = peak_at[15:0];
		r.sil = s;
		r.lst = ls;
		return r;
	endfunction

	function automatic void clear_meter();
		energy_acc = 0;
		samp_cnt = 0;
		frames = 0;
		peak_lvl = 0;
		peak_at = 0;
		lvl_sum = 0;
	endfunction

	// predict the records one sample causes
	function automatic void predict_sample(logic signed [15:0] s, logic eos);
		longint unsigned ln;
		longint sq;
		int lvl;
		logic sil;
		ln = (len_reg == 0) ? 1 : ((len_reg > MAXLEN) ? MAXLEN : len_reg);
		sq = longint'(s) * longint'(s);
		energy_acc = (energy_acc + sq) & ((64'd1 << 43) - 1);
		samp_cnt++;
		if (samp_cnt >= ln || eos) begin
			if (energy_acc == 0) begin
				sil = 1'b1;
				lvl = int'(FLOOR_DB);
			end else begin
				sil = 1'b0;
				lvl = frame_level(energy_acc, ln);
			end
			if (frames < 65535) frames++;
			if (lvl > peak_lvl) begin
				peak_lvl = lvl;
				peak_at = frames;
			end
			lvl_sum += lvl;
			if (lvl_sum > 64'sd2147483647) lvl_sum = 64'sd2147483647;
			if (lvl_sum < -64'sd2147483648) lvl_sum = -64'sd2147483648;
			pending_recs.push_back(make_rec(REC_FRAME, frames, lvl, sil, !eos));
			energy_acc = 0;
			samp_cnt = 0;
		end
		if (eos) begin
			longint avg;
			longint unsigned mg, q;
			avg = 0;
			if (frames != 0) begin
				mg = (lvl_sum < 0) ? longint'(-lvl_sum) : lvl_sum;
				q = (mg + frames / 2) / frames;
				avg = (lvl_sum < 0) ? -longint'(q) : longint'(q);
				if (avg > 25600) avg = 25600;
				if (avg < -25600) avg = -25600;
			end
			pending_recs.push_back(make_rec(REC_SUMMARY, frames, int'(avg), 1'b0, 1'b1));
			clear_meter();
		end
	endfunction

	// send one sample, with a random gap before it at times while idle_on is set
	task automatic send_sample(logic signed [15:0] s, logic eos);
		if (idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 16)) @(posedge clk);
		else
			@(posedge clk);
		in_valid <= 1'b1;
		sample <= s;
		end_of_stream <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_sample(s, eos);
		items_sent++;
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_recs.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_length(logic [12:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		len_reg = v;
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sd0;
			3: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom());
		endcase
	endfunction

	// result checking
	always @(posedge clk) begin
		meter_rec_t e;
		if (out_valid && out_ready) begin
			recs_seen++;
			if (record_kind == REC_SUMMARY) summaries_seen++;
			else frames_seen++;
			if (pending_recs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected record kind=%0d num=%0d",
					record_kind, frame_number);
			end else begin
				e = pending_recs.pop_front();
				if (e.kind !== record_kind || e.num !== frame_number ||
						e.lvl !== level_db || e.pk !== peak_db || e.pkf !== peak_frame ||
						e.sil !== silent || e.lst !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp k%0d n%0d l%0d p%0d pf%0d s%0d t%0d got k%0d n%0d l%0d p%0d pf%0d s%0d t%0d",
							e.kind, e.num, $signed(e.lvl), e.pk, e.pkf, e.sil, e.lst,
							record_kind, frame_number, level_db, peak_db, peak_frame,
							silent, last);
				end
			end
		end
	end

	// receiver stall bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 16);
				out_ready <= 1'b0;
			end else begin
				n = $urandom_range(1, 20);
				out_ready <= 1'b1;
			end
			repeat (n) @(posedge clk);
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
			else quiet++;
			if (quiet >= 20000) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
		set_length(13'd1);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sd0, 1'b1);
		set_length(13'd0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd0, 1'b1);
		set_length(13'd3);
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sh5555, 1'b0);
		send_sample(16'shaaaa, 1'b1);
		set_length(13'h1fff);
		send_sample(16'sh7fff, 1'b1);
	endtask

	// mid-frame length change with state kept
	task automatic test_length_change();
		set_length(13'd8);
		repeat (5) send_sample(rand_sample(), 1'b0);
		set_length(13'd4);
		send_sample(16'sd100, 1'b0);
		send_sample(16'sd100, 1'b1);
	endtask

	task automatic test_random(int count);
		logic [12:0] lens[6] = '{13'd1, 13'd2, 13'd7, 13'd16, 13'd4096, 13'd5000};
		int sent;
		sent = 0;
		while (sent < count) begin
			int l;
			l = int'(lens[$urandom_range(0, 5)]);
			if (l >= 4096 && $urandom_range(0, 3) != 0) l = int'($urandom_range(1, 12));
			set_length(l[12:0]);
			repeat ($urandom_range(1, 4)) begin
				int n;
				n = (l > 100) ? int'($urandom_range(1, 60)) : int'($urandom_range(1, 4 * l + 3));
				for (int i = 0; i < n; i++) begin
					send_sample(rand_sample(),
						(i == n - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
					sent++;
				end
			end
			send_sample(rand_sample(), 1'b1);
			sent++;
		end
	endtask

	// long stream of one-sample frames, without input gaps or receiver stalls
	task automatic test_full_rate(int count);
		idle_on = 1'b0;
		set_length(13'd1);
		for (int i = 0; i < count; i++) send_sample(rand_sample(), i == count - 1);
	endtask

	initial begin
		len_reg = DEFAULT_LEN;
		clear_meter();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_length_change();
		test_random(1000);
		test_full_rate(200);
		wait_drained();
		$display("sent %0d samples, checked %0d records (%0d frame, %0d summary)",
			items_sent, recs_seen, frames_seen, summaries_seen);
		$display("frame lengths 0 to 8191, silent frames, extreme samples, stalls");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end
endmodule
